// ===== hw/rtl/sld_pkg.sv =====
// Shared constants, types and codes of the sync/length frame decoder.
`default_nettype none
package sld_pkg;

  localparam int BUFFER_DEPTH = 128;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] FRAME_ID    = 8'h38;
  localparam logic [7:0] MOD_ANALOG  = 8'h07;
  localparam logic [7:0] MOD_MOTOR   = 8'h08;
  localparam logic [7:0] METH_LOW    = 8'h60;
  localparam logic [7:0] METH_HIGH   = 8'h61;
  localparam logic [8:0] LEN_EXTRA   = 9'd8;

  localparam logic [7:0] IDX_LENGTH = 8'd3;
  localparam logic [7:0] IDX_START  = 8'd2;

  localparam logic [ADDR_W-1:0] ADDR_ID     = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] ADDR_MODULE = ADDR_W'(4);
  localparam logic [ADDR_W-1:0] ADDR_METHOD = ADDR_W'(5);
  localparam logic [ADDR_W-1:0] ADDR_DATA   = ADDR_W'(7);

  localparam logic KIND_ANALOG = 1'b0;
  localparam logic KIND_MOTOR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_TAKE,
    ST_EMIT
  } dec_state_t;

  typedef enum logic [1:0] {
    PH_ID,
    PH_MODULE,
    PH_METHOD,
    PH_DATA
  } dec_phase_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sld_if.sv =====
// Handshake channels: received bytes in, decoded records out.
`default_nettype none
interface sld_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sld_res_if;
  logic               valid;
  logic               ready;
  logic               record_kind;
  logic [3:0]         slot;
  logic [15:0]        analog_value;
  logic signed [31:0] motor_position;
  logic signed [15:0] motor_current;
  logic               last_of_frame;

  modport source (output valid, output record_kind, output slot, output analog_value,
                  output motor_position, output motor_current, output last_of_frame,
                  input ready);
  modport sink   (input valid, input record_kind, input slot, input analog_value,
                  input motor_position, input motor_current, input last_of_frame,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sld_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sld_store.sv =====
// Frame store: RAM plus per-entry valid bits so unwritten entries read as zero.
`default_nettype none
module sld_store
  import sld_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire wr_req_t wr,
  input  wire rd_req_t rd,
  output logic [7:0]   rd_data
);

  logic [BUFFER_DEPTH-1:0] written;
  logic                    rd_written;
  logic [7:0]              ram_data;

  sld_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd.en),
    .rd_addr (rd.addr),
    .rd_data (ram_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_written <= written[rd.addr];
      end
    end
  end

  assign rd_data = rd_written ? ram_data : 8'd0;

endmodule
`default_nettype wire

// ===== hw/rtl/sld_writer.sv =====
// Sync hunt, frame length tracking and store writes for incoming bytes.
`default_nettype none
module sld_writer
  import sld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output wr_req_t         wr,
  output logic            start
);

  logic [7:0] previous_byte;
  logic       in_frame;
  logic [7:0] write_index;
  logic [8:0] expected_length;

  logic [8:0] index_next;
  logic [8:0] length_eff;
  logic       complete;
  logic       overflow;

  always_comb begin
    index_next = {1'b0, write_index} + 9'd1;
    length_eff = (write_index == IDX_LENGTH) ? ({1'b0, rx_byte} + LEN_EXTRA)
                                             : expected_length;
    complete   = (index_next == length_eff);
    overflow   = (index_next >= 9'(BUFFER_DEPTH));
    wr.en      = accept && in_frame && ({1'b0, write_index} < 9'(BUFFER_DEPTH));
    wr.addr    = write_index[ADDR_W-1:0];
    wr.data    = rx_byte;
    start      = accept && in_frame && complete;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte   <= 8'd0;
      in_frame        <= 1'b0;
      write_index     <= 8'd0;
      expected_length <= 9'd2;
    end else if (accept) begin
      if (!in_frame) begin
        if (previous_byte == SYNC_FIRST && rx_byte == SYNC_SECOND) begin
          in_frame      <= 1'b1;
          write_index   <= IDX_START;
          previous_byte <= 8'd0;
        end else begin
          previous_byte <= rx_byte;
        end
      end else begin
        if (write_index == IDX_LENGTH) begin
          expected_length <= length_eff;
        end
        write_index <= index_next[7:0];
        if (complete || overflow) begin
          in_frame <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sld_decoder.sv =====
// Read sequencer over the frame store and result output register.
`default_nettype none
module sld_decoder
  import sld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [7:0] rd_data,
  output rd_req_t         rd,
  output logic            busy,
  sld_res_if.source       res
);

  dec_state_t        state, state_next;
  dec_phase_t        phase, phase_next;
  logic [ADDR_W-1:0] rd_addr, rd_addr_next;
  logic [2:0]        byte_cnt, byte_cnt_next;
  logic [2:0]        rec_cnt, rec_cnt_next;
  logic              kind, kind_next;
  logic              base_hi, base_hi_next;
  logic [47:0]       acc, acc_next;

  logic              res_valid, res_valid_next;
  logic              load;
  logic              rec_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
    phase    <= phase_next;
    rd_addr  <= rd_addr_next;
    byte_cnt <= byte_cnt_next;
    rec_cnt  <= rec_cnt_next;
    kind     <= kind_next;
    base_hi  <= base_hi_next;
    acc      <= acc_next;
    if (load) begin
      res.record_kind    <= kind;
      res.slot           <= {base_hi, 3'(rec_cnt)} | {1'b0, rec_cnt};
      res.analog_value   <= (kind == KIND_ANALOG) ? acc[15:0] : 16'd0;
      res.motor_position <= (kind == KIND_MOTOR) ? acc[47:16] : 32'sd0;
      res.motor_current  <= (kind == KIND_MOTOR) ? acc[15:0] : 16'sd0;
      res.last_of_frame  <= rec_last;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    rd_addr_next  = rd_addr;
    byte_cnt_next = byte_cnt;
    rec_cnt_next  = rec_cnt;
    kind_next     = kind;
    base_hi_next  = base_hi;
    acc_next      = acc;
    rd.en         = 1'b0;
    rd.addr       = rd_addr;
    load          = 1'b0;
    rec_last      = (kind == KIND_MOTOR) ? (rec_cnt == 3'd3) : (rec_cnt == 3'd7);
    res_valid_next = res_valid && !res.ready;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          phase_next   = PH_ID;
          rd_addr_next = ADDR_ID;
          state_next   = ST_READ;
        end
      end
      ST_READ: begin
        rd.en      = 1'b1;
        state_next = ST_TAKE;
      end
      ST_TAKE: begin
        unique case (phase)
          PH_ID: begin
            if (rd_data == FRAME_ID) begin
              phase_next   = PH_MODULE;
              rd_addr_next = ADDR_MODULE;
              state_next   = ST_READ;
            end else begin
              state_next = ST_IDLE;
            end
          end
          PH_MODULE: begin
            if (rd_data == MOD_ANALOG) begin
              phase_next   = PH_METHOD;
              rd_addr_next = ADDR_METHOD;
              state_next   = ST_READ;
            end else if (rd_data == MOD_MOTOR) begin
              kind_next     = KIND_MOTOR;
              base_hi_next  = 1'b0;
              phase_next    = PH_DATA;
              rd_addr_next  = ADDR_DATA;
              byte_cnt_next = 3'd0;
              rec_cnt_next  = 3'd0;
              state_next    = ST_READ;
            end else begin
              state_next = ST_IDLE;
            end
          end
          PH_METHOD: begin
            if (rd_data == METH_LOW || rd_data == METH_HIGH) begin
              kind_next     = KIND_ANALOG;
              base_hi_next  = (rd_data == METH_HIGH);
              phase_next    = PH_DATA;
              rd_addr_next  = ADDR_DATA;
              byte_cnt_next = 3'd0;
              rec_cnt_next  = 3'd0;
              state_next    = ST_READ;
            end else begin
              state_next = ST_IDLE;
            end
          end
          PH_DATA: begin
            acc_next      = {acc[39:0], rd_data};
            rd_addr_next  = rd_addr + ADDR_W'(1);
            byte_cnt_next = byte_cnt + 3'd1;
            if (byte_cnt == ((kind == KIND_MOTOR) ? 3'd5 : 3'd1)) begin
              state_next = ST_EMIT;
            end else begin
              state_next = ST_READ;
            end
          end
        endcase
      end
      ST_EMIT: begin
        if (!res_valid || res.ready) begin
          load           = 1'b1;
          res_valid_next = 1'b1;
          byte_cnt_next  = 3'd0;
          rec_cnt_next   = rec_cnt + 3'd1;
          state_next     = rec_last ? ST_IDLE : ST_READ;
        end
      end
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign res.valid = res_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/sync_length_frame_decoder_core.sv =====
// Top level of the sync/length frame decoder.
// Takes one received byte per transaction, one per cycle while no frame is
// being decoded. The byte that completes a frame starts a decode pass over
// the frame store, during which rx.ready is low: each store byte is read on
// the single read port in a read state and taken in a take state, and each
// record then passes an emit state to load the output register, which waits
// out any stall on the result channel; a frame with an unknown ID, module or
// method ends the pass early. Results leave through an output register, so
// the next bytes are taken while the final record still waits. Stored bytes
// are tracked by per-entry valid bits, so no clearing pass follows reset.
// Frames longer than the buffer are dropped.
`default_nettype none
module sync_length_frame_decoder_core
  import sld_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sld_rx_if.sink    rx,
  sld_res_if.source res
);

  wr_req_t    wr;
  rd_req_t    rd;
  logic [7:0] rd_data;
  logic       start;
  logic       busy;

  assign rx.ready = !busy;

  sld_writer u_writer (
    .clk     (clk),
    .rst     (rst),
    .accept  (rx.valid && rx.ready),
    .rx_byte (rx.rx_byte),
    .wr      (wr),
    .start   (start)
  );

  sld_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  sld_decoder u_decoder (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .rd_data (rd_data),
    .rd      (rd),
    .busy    (busy),
    .res     (res)
  );

endmodule
`default_nettype wire
